/* sv/svm_pkg.sv */
// Package for the sample voice mixer: sizes, payload word types, command codes
// and the controller-to-datapath command and status structs.
// Used by every module of the block; depends on nothing.
package svm_pkg;

  localparam int VOICES      = 8;
  localparam int SOUNDS      = 8;
  localparam int SOUND_DEPTH = 65536;

  localparam int VOI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SND_W  = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
  localparam int DEP_W  = $clog2(SOUND_DEPTH);
  localparam int LEN_W  = $clog2(SOUND_DEPTH + 1);
  localparam int ADDR_W = SND_W + DEP_W;
  localparam int MEM_DEPTH = SOUNDS * SOUND_DEPTH;

  localparam logic [15:0] UNITY_GAIN = 16'd32768;
  localparam int          FULL_SCALE = 32767;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE   = 2'd1;

  // Input word commands.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PLAY    = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;
  localparam logic [1:0] CMD_SET_LEN = 2'd3;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd1;
  localparam logic [OP_W-1:0] OP_STEP       = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd3;
  localparam logic [OP_W-1:0] OP_SET_LEN    = 4'd4;
  localparam logic [OP_W-1:0] OP_START_IDLE = 4'd5;
  localparam logic [OP_W-1:0] OP_SCAN       = 4'd6;
  localparam logic [OP_W-1:0] OP_START_BEST = 4'd7;
  localparam logic [OP_W-1:0] OP_EMIT       = 4'd8;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         sound_id;
    logic [15:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [16:0]        sound_len;
  } svm_in_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic [3:0]         active_voices;
  } svm_out_t;

  typedef struct packed {
    logic            latch;
    logic [OP_W-1:0] op;
    logic [VOI_W-1:0] voice;
  } svm_cmd_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic       play_ok;
    logic       has_idle;
    logic       out_free;
  } svm_status_t;

endpackage

/* sv/svm_ctrl.sv */
// Controller state machine of the sample voice mixer: accepts words and
// sequences the datapath through ticks, plays, loads and length writes.
// Depends on svm_pkg.
module svm_ctrl
  import svm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  svm_status_t status_i,
  output svm_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_TICK   = 3'd2;
  localparam logic [2:0] ST_DRAIN1 = 3'd3;
  localparam logic [2:0] ST_DRAIN2 = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;
  localparam logic [2:0] ST_SCAN   = 3'd6;
  localparam logic [2:0] ST_START  = 3'd7;

  localparam logic [VOI_W-1:0] LAST_VOICE = VOI_W'(VOICES - 1);

  logic [2:0]       state_q, state_d;
  logic [VOI_W-1:0] voice_q, voice_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    voice_d      = voice_q;
    cmd_o.latch  = 1'b0;
    cmd_o.op     = OP_NONE;
    cmd_o.voice  = voice_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        voice_d = '0;
        unique case (status_i.item_cmd)
          CMD_TICK: begin
            cmd_o.op = OP_CLEAR;
            state_d  = ST_TICK;
          end
          CMD_PLAY: begin
            if (!status_i.play_ok) begin
              state_d = ST_IDLE;
            end else if (status_i.has_idle) begin
              cmd_o.op = OP_START_IDLE;
              state_d  = ST_IDLE;
            end else begin
              cmd_o.op = OP_CLEAR;
              state_d  = ST_SCAN;
            end
          end
          CMD_LOAD: begin
            cmd_o.op = OP_LOAD;
            state_d  = ST_IDLE;
          end
          default: begin
            cmd_o.op = OP_SET_LEN;
            state_d  = ST_IDLE;
          end
        endcase
      end
      ST_TICK: begin
        cmd_o.op = OP_STEP;
        voice_d  = voice_q + VOI_W'(1);
        if (voice_q == LAST_VOICE) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        state_d = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        voice_d  = voice_q + VOI_W'(1);
        if (voice_q == LAST_VOICE) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.op = OP_START_BEST;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      voice_q <= '0;
    end else begin
      state_q <= state_d;
      voice_q <= voice_d;
    end
  end

endmodule

/* sv/svm_datapath.sv */
// Datapath of the sample voice mixer: configuration registers, sample store,
// sound lengths, voice state, the three-stage mix pipeline and the output register.
// Depends on svm_pkg; driven by svm_ctrl.
module svm_datapath
  import svm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  svm_in_t               in_i,
  input  logic                  cfg_wr_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  svm_cmd_t              cmd_i,
  output svm_status_t           status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output svm_out_t              out_o
);

  logic [15:0] volume_q;
  logic        mute_q;

  svm_in_t item_q;

  logic [15:0]       mem [MEM_DEPTH];
  logic [LEN_W-1:0]  sound_len_q [SOUNDS];
  logic [VOICES-1:0] voice_active_q;
  logic [SND_W-1:0]  voice_sound_q [VOICES];
  logic [LEN_W-1:0]  voice_pos_q [VOICES];

  logic signed [15:0] rd_q;
  logic               s1_live_q;
  logic signed [31:0] prod_q;
  logic               s2_live_q;
  logic signed [15:0] sum_q;

  logic [VOI_W-1:0] best_q;
  logic [LEN_W-1:0] best_pos_q;

  svm_out_t out_q;
  logic     out_valid_q;

  // Item decode.
  logic [SND_W-1:0]  item_snd;
  logic              snd_ok;
  logic              load_ok;
  logic [31:0]       idx_ext;
  logic [ADDR_W-1:0] load_addr;
  logic [LEN_W-1:0]  len_sat;

  assign item_snd  = SND_W'(item_q.sound_id);
  assign snd_ok    = 32'(item_q.sound_id) < SOUNDS;
  assign idx_ext   = 32'(item_q.sample_index);
  assign load_ok   = snd_ok && (idx_ext < SOUND_DEPTH);
  assign load_addr = {item_snd, idx_ext[DEP_W-1:0]};
  assign len_sat   = (32'(item_q.sound_len) > SOUND_DEPTH) ? LEN_W'(SOUND_DEPTH)
                                                           : LEN_W'(item_q.sound_len);

  // First idle voice.
  logic             has_idle;
  logic [VOI_W-1:0] idle_idx;

  always_comb begin
    has_idle = 1'b0;
    idle_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!voice_active_q[i]) begin
        has_idle = 1'b1;
        idle_idx = VOI_W'(i);
      end
    end
  end

  // Voice addressed by the controller.
  logic [SND_W-1:0]  step_snd;
  logic [LEN_W-1:0]  step_pos;
  logic              step_expire;
  logic [ADDR_W-1:0] rd_addr;

  assign step_snd    = voice_sound_q[cmd_i.voice];
  assign step_pos    = voice_pos_q[cmd_i.voice];
  assign step_expire = (step_pos >= sound_len_q[step_snd])
                    || (step_pos >= LEN_W'(SOUND_DEPTH));
  assign rd_addr     = {step_snd, step_pos[DEP_W-1:0]};

  logic do_step;
  logic step_live;
  assign do_step   = (cmd_i.op == OP_STEP);
  assign step_live = do_step && voice_active_q[cmd_i.voice] && !step_expire;

  // Gain and accumulation.
  logic [15:0]        gain;
  logic signed [32:0] total;
  logic signed [32:0] biased;
  logic signed [32:0] quot;
  logic signed [15:0] sum_next;

  assign gain = mute_q ? 16'd0 : ((volume_q > UNITY_GAIN) ? UNITY_GAIN : volume_q);

  always_comb begin
    total  = $signed({{2{sum_q[15]}}, sum_q, 15'b0}) + 33'(prod_q);
    biased = total[32] ? (total + 33'sd32767) : total;
    quot   = biased >>> 15;
    if (quot > 33'(FULL_SCALE)) begin
      sum_next = 16'(FULL_SCALE);
    end else if (quot < -33'(FULL_SCALE)) begin
      sum_next = -16'(FULL_SCALE);
    end else begin
      sum_next = 16'(quot);
    end
  end

  assign status_o.item_cmd = item_q.cmd;
  assign status_o.play_ok  = snd_ok && (sound_len_q[item_snd] != '0);
  assign status_o.has_idle = has_idle;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= 16'd16384;
      mute_q   <= 1'b0;
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        CFG_VOLUME: volume_q <= cfg_data_i[15:0];
        CFG_MUTE:   mute_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && load_ok) begin
      mem[load_addr] <= item_q.sample_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_live) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SOUNDS; i++) begin
        sound_len_q[i] <= '0;
      end
    end else if (cmd_i.op == OP_SET_LEN && snd_ok) begin
      sound_len_q[item_snd] <= len_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_active_q <= '0;
      for (int i = 0; i < VOICES; i++) begin
        voice_sound_q[i] <= '0;
        voice_pos_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.op == OP_START_IDLE) begin
        voice_active_q[idle_idx] <= 1'b1;
        voice_sound_q[idle_idx]  <= item_snd;
        voice_pos_q[idle_idx]    <= '0;
      end else if (cmd_i.op == OP_START_BEST) begin
        voice_active_q[best_q] <= 1'b1;
        voice_sound_q[best_q]  <= item_snd;
        voice_pos_q[best_q]    <= '0;
      end else if (do_step && voice_active_q[cmd_i.voice]) begin
        if (step_expire) begin
          voice_active_q[cmd_i.voice] <= 1'b0;
        end else begin
          voice_pos_q[cmd_i.voice] <= step_pos + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 32'(rd_q * $signed({1'b0, gain}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_live_q  <= 1'b0;
      s2_live_q  <= 1'b0;
      sum_q      <= '0;
      best_q     <= '0;
      best_pos_q <= '0;
    end else begin
      s1_live_q <= step_live;
      s2_live_q <= s1_live_q;
      if (cmd_i.op == OP_CLEAR) begin
        sum_q      <= '0;
        best_q     <= '0;
        best_pos_q <= '0;
      end else begin
        if (s2_live_q) begin
          sum_q <= sum_next;
        end
        if (cmd_i.op == OP_SCAN && step_pos > best_pos_q) begin
          best_q     <= cmd_i.voice;
          best_pos_q <= step_pos;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_q.out_sample    <= sum_q;
      out_q.active_voices <= 4'($countones(voice_active_q));
    end
  end

endmodule

/* sv/sample_voice_mixer.sv */
// Top level of the sample voice mixer: joins the controller and the datapath.
// Depends on svm_pkg, svm_ctrl and svm_datapath.
//
// Eight-voice sample playback mixer working on one word at a time. A load,
// set-length or play word passes through the decode state and returns to
// idle; a play when every voice is busy first walks over the voices and
// steals the longest-running one before it returns. A tick passes through
// the decode state, a store read for each voice in turn, the drain states
// ST_DRAIN1 and ST_DRAIN2 while the multiply and accumulate pipeline empties,
// and the emit state that places the mixed sample in the output register,
// plus any wait for the previous output word to be taken. The next word is
// accepted while that result waits to be taken. The sample store has no
// reset; a word must be loaded before any voice plays it.
module sample_voice_mixer
  import svm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  svm_in_t               in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output svm_out_t              out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  svm_cmd_t    cmd;
  svm_status_t status;

  assign cfg_ready_o = 1'b1;

  svm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

/* tb/tb_sample_voice_mixer.sv */
// Self-checking testbench for sample_voice_mixer: sends command words, predicts every mixed
// output word with its own model of the voices and the sample store, and checks each one.
// Depends on svm_pkg and sample_voice_mixer.
module tb_sample_voice_mixer;
  import svm_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int FILL_CAP      = 48;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  svm_in_t               in_word;
  logic                  out_valid;
  logic                  out_ready;
  svm_out_t              out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [15:0] store_words [int];
  int          snd_len [SOUNDS];
  int          filled [SOUNDS];
  bit          v_act [VOICES];
  int          v_snd [VOICES];
  int          v_pos [VOICES];
  int          gain_reg;
  bit          mute_reg;
  svm_out_t    pending_mixes [$];
  svm_out_t    due_mix;

  int errors;
  int words_sent;
  int samples_checked;
  int steals;
  int reg_writes;
  int quiet;
  bit gaps_on;
  bit stalls_on;
  bit hold_request;

  sample_voice_mixer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void start_sound(int s);
    int best;
    int best_pos;
    if (snd_len[s] == 0) return;
    for (int v = 0; v < VOICES; v++) begin
      if (!v_act[v]) begin
        v_act[v] = 1'b1;
        v_snd[v] = s;
        v_pos[v] = 0;
        return;
      end
    end
    best = 0;
    best_pos = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (v_pos[v] > best_pos) begin
        best_pos = v_pos[v];
        best = v;
      end
    end
    steals++;
    v_snd[best] = s;
    v_pos[best] = 0;
  endfunction

  function automatic svm_out_t mix_tick();
    svm_out_t res;
    longint   acc;
    longint   gain;
    longint   unity;
    longint   total;
    int       s;
    int       p;
    int       n;
    unity = longint'(UNITY_GAIN);
    gain = mute_reg ? 0 : ((gain_reg > unity) ? unity : gain_reg);
    acc = 0;
    n = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (v_act[v]) begin
        s = v_snd[v];
        p = v_pos[v];
        if (p >= snd_len[s] || p >= SOUND_DEPTH) begin
          v_act[v] = 1'b0;
        end else begin
          total = acc * unity + longint'($signed(store_words[s * SOUND_DEPTH + p])) * gain;
          acc = total / unity;
          if (acc > FULL_SCALE) acc = longint'(FULL_SCALE);
          if (acc < -FULL_SCALE) acc = longint'(-FULL_SCALE);
          v_pos[v] = p + 1;
        end
      end
    end
    for (int v = 0; v < VOICES; v++) begin
      if (v_act[v]) n++;
    end
    res.out_sample = acc[15:0];
    res.active_voices = n[3:0];
    return res;
  endfunction

  function automatic svm_in_t noise_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(svm_in_t)-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(svm_in_t w);
    int key;
    int s;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    s = int'(w.sound_id);
    case (w.cmd)
      CMD_TICK: pending_mixes.push_back(mix_tick());
      CMD_PLAY: start_sound(s);
      CMD_LOAD: begin
        key = s * SOUND_DEPTH + int'(w.sample_index);
        store_words[key] = w.sample_value;
        while (filled[s] < SOUND_DEPTH && store_words.exists(s * SOUND_DEPTH + filled[s]))
          filled[s]++;
      end
      default: snd_len[s] = (w.sound_len > SOUND_DEPTH) ? SOUND_DEPTH : int'(w.sound_len);
    endcase
    @(negedge clk);
  endtask

  task automatic tick_word();
    svm_in_t w;
    w = noise_word();
    w.cmd = CMD_TICK;
    send_word(w);
  endtask

  task automatic play_word(int s);
    svm_in_t w;
    w = noise_word();
    w.cmd = CMD_PLAY;
    w.sound_id = 3'(s);
    send_word(w);
  endtask

  task automatic load_word(int s, int idx, logic [15:0] value);
    svm_in_t w;
    w = noise_word();
    w.cmd = CMD_LOAD;
    w.sound_id = 3'(s);
    w.sample_index = 16'(idx);
    w.sample_value = value;
    send_word(w);
  endtask

  task automatic length_word(int s, int len);
    svm_in_t w;
    w = noise_word();
    w.cmd = CMD_SET_LEN;
    w.sound_id = 3'(s);
    w.sound_len = 17'(len);
    send_word(w);
  endtask

  // Lengths never exceed the loaded prefix of a sound, so no voice reads an unwritten word.
  task automatic send_random_word();
    svm_in_t w;
    int      s;
    int      pick;
    w = noise_word();
    s = $urandom_range(0, SOUNDS - 1);
    pick = $urandom_range(0, 99);
    w.sound_id = 3'(s);
    if (pick < 40) begin
      w.cmd = CMD_TICK;
    end else if (pick < 62) begin
      w.cmd = CMD_PLAY;
    end else if (pick < 88) begin
      w.cmd = CMD_LOAD;
      case ($urandom_range(0, 9))
        0: w.sample_value = 16'h7FFF;
        1: w.sample_value = 16'h8000;
        default: w.sample_value = 16'($urandom);
      endcase
      if (pick < 84) begin
        if (filled[s] < FILL_CAP) w.sample_index = 16'(filled[s]);
        else w.sample_index = 16'($urandom_range(0, filled[s] - 1));
      end
    end else begin
      w.cmd = CMD_SET_LEN;
      w.sound_len = 17'($urandom_range(0, filled[s]));
    end
    send_word(w);
  endtask

  task automatic run_random(int count);
    repeat (count) send_random_word();
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_mixes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    if (idx == CFG_VOLUME) gain_reg = int'(data);
    else if (idx == CFG_MUTE) mute_reg = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [15:0] vol, bit mute);
    logic [15:0] r;
    r = 16'($urandom);
    r[0] = mute;
    drain_block();
    write_reg(CFG_VOLUME, vol);
    write_reg(CFG_MUTE, r);
  endtask

  task automatic test_empty_sound();
    tick_word();
    play_word(0);
  endtask

  // Eight plays fill every voice at position zero, so the ninth steals the first voice.
  task automatic test_saturation_and_steal();
    load_word(0, 0, 16'h7FFF);
    load_word(0, 1, 16'h8000);
    load_word(0, 2, 16'hFFFF);
    length_word(0, 3);
    load_word(1, 0, 16'h8000);
    length_word(1, 1);
    repeat (8) play_word(0);
    play_word(1);
    repeat (3) tick_word();
  endtask

  task automatic test_length_extremes();
    load_word(7, 0, 16'h1234);
    length_word(7, 131071);
    length_word(7, SOUND_DEPTH);
    play_word(7);
    tick_word();
    length_word(7, 1);
    tick_word();
  endtask

  task automatic test_register_settings();
    apply_settings(16'd0, 1'b0);
    run_random(300);
    apply_settings(16'hFFFF, 1'b0);
    run_random(300);
    apply_settings(16'd32769, 1'b1);
    run_random(300);
    apply_settings(16'($urandom_range(1, 32767)), 1'b0);
    run_random(300);
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    run_random(80);
    drain_block();
  endtask

  task automatic test_sender_pause();
    repeat (5) begin
      run_random(20);
      drain_block();
    end
  endtask

  task automatic test_unthrottled();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    apply_settings(16'($urandom_range(1, 32768)), 1'b0);
    run_random(400);
    drain_block();
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_mixes.size() == 0) begin
        errors++;
        $display("%0t: output word with nothing expected, got sample %0d voices %0d",
                 $time, out_word.out_sample, out_word.active_voices);
      end else begin
        due_mix = pending_mixes.pop_front();
        samples_checked++;
        if (out_word.out_sample !== due_mix.out_sample) begin
          errors++;
          $display("%0t: out_sample expected %0d, got %0d",
                   $time, due_mix.out_sample, out_word.out_sample);
        end
        if (out_word.active_voices !== due_mix.active_voices) begin
          errors++;
          $display("%0t: active_voices expected %0d, got %0d",
                   $time, due_mix.active_voices, out_word.active_voices);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Stalled for %0d cycles with %0d output words outstanding.",
                 quiet, pending_mixes.size());
        $display("tb_sample_voice_mixer: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VOLUME;
    cfg_data = '0;
    errors = 0;
    words_sent = 0;
    samples_checked = 0;
    steals = 0;
    reg_writes = 0;
    quiet = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_request = 1'b0;
    gain_reg = 16384;
    mute_reg = 1'b0;
    for (int i = 0; i < SOUNDS; i++) begin
      snd_len[i] = 0;
      filled[i] = 0;
    end
    for (int i = 0; i < VOICES; i++) begin
      v_act[i] = 1'b0;
      v_snd[i] = 0;
      v_pos[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apply_settings(UNITY_GAIN, 1'b0);
    test_empty_sound();
    test_saturation_and_steal();
    test_length_extremes();
    test_register_settings();
    test_output_backpressure();
    test_sender_pause();
    test_unthrottled();

    $display("Sent %0d command words under six gain settings; %0d mixed samples checked,",
             words_sent, samples_checked);
    $display("%0d voice steals seen and %0d register writes made.", steals, reg_writes);
    if (errors == 0) begin
      $display("tb_sample_voice_mixer: done, clean");
    end else begin
      $display("tb_sample_voice_mixer: done, errors");
    end
    $finish;
  end

endmodule

/* sample_voice_mixer.f */
sv/svm_pkg.sv
sv/svm_ctrl.sv
sv/svm_datapath.sv
sv/sample_voice_mixer.sv
tb/tb_sample_voice_mixer.sv
